FILE: rtl/lrs_pkg.sv
// Shared types and constants for the latency running statistics block.
`timescale 1ns / 1ps

package lrs_pkg;

    // Field widths of a sample and of the running state.
    localparam int SEC_BITS    = 12;
    localparam int USEC_BITS   = 20;
    localparam int SAMPLE_BITS = SEC_BITS + USEC_BITS;
    localparam int FRAC_BITS   = 16;
    localparam int COUNT_BITS  = 32;
    localparam int US_BITS     = 32;
    localparam int MEAN_BITS   = US_BITS + FRAC_BITS;
    localparam int SUM_BITS    = 64;
    localparam int STD_BITS    = 32;

    // Width of the shared adder and of the multiply accumulator.
    localparam int ALU_BITS  = 64;
    localparam int PROD_BITS = 2 * MEAN_BITS;

    // Iteration counts of the serial divide, multiply and square root.
    localparam int ITER_BITS   = 6;
    localparam int DIV1_STEPS  = MEAN_BITS;
    localparam int DIV2_STEPS  = SUM_BITS;
    localparam int MUL_STEPS   = MEAN_BITS;
    localparam int SQRT_STEPS  = SUM_BITS / 2;

    localparam logic [US_BITS-1:0] USEC_PER_SEC = 32'd1000000;

    // Operation of the shared adder.
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

FILE: rtl/lrs_alu.sv
// Shared add/subtract unit with carry out, reused by the arithmetic steps of the sequencer.
`timescale 1ns / 1ps

module lrs_alu import lrs_pkg::*; (
    input  t_alu_op             i_op,
    input  logic [ALU_BITS-1:0] i_a,
    input  logic [ALU_BITS-1:0] i_b,
    output logic [ALU_BITS-1:0] o_res,
    output logic                o_carry
);

    logic [ALU_BITS-1:0] w_b;
    logic [ALU_BITS:0]   w_sum;
    logic                w_sub;

    // A subtract is an add of the inverted operand plus one; carry set means no borrow.
    assign w_sub   = (i_op == ALU_SUB);
    assign w_b     = w_sub ? ~i_b : i_b;
    assign w_sum   = {1'b0, i_a} + {1'b0, w_b} + {{ALU_BITS{1'b0}}, w_sub};
    assign o_res   = w_sum[ALU_BITS-1:0];
    assign o_carry = w_sum[ALU_BITS];

endmodule

FILE: rtl/latency_running_statistics_top.sv
// Top level of the latency running statistics block: sequencer, state and output register.
`timescale 1ns / 1ps
// Usage:
// The input channel takes one latency sample (seconds and microseconds) per
// transaction on i_in_valid / o_in_stall. The output channel returns one result
// per sample on o_out_valid / i_out_stall: the sample count, the running mean in
// microseconds with 16 fraction bits, the sample standard deviation in whole
// microseconds, and the smallest and largest samples seen.
// Each sample runs through one shared 64-bit adder under a sequencer: a 48-step
// restoring divide for the mean update, a 48-step shift-add multiply of the old
// and new deviation magnitudes, a 64-step divide of the sum by count - 1 and a
// 32-step integer square root; the last two are skipped while the count is
// below two. The block takes one sample at a time: o_in_stall is high while a
// sample is being worked on.
// The result sits in an output register; a new sample is accepted while it
// waits. If the receiver still stalls when the next result is done, the
// sequencer holds that result until the output register frees up.
// Synchronous reset clears the count, mean, sum, minimum and maximum to zero.

module latency_running_statistics_top import lrs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SEC_BITS-1:0]    i_sample_sec,
    input  logic [USEC_BITS-1:0]   i_sample_usec,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [COUNT_BITS-1:0]  o_sample_count,
    output logic [MEAN_BITS-1:0]   o_mean_q16,
    output logic [STD_BITS-1:0]    o_std_dev_us,
    output logic [SEC_BITS-1:0]    o_min_sec,
    output logic [USEC_BITS-1:0]   o_min_usec,
    output logic [SEC_BITS-1:0]    o_max_sec,
    output logic [USEC_BITS-1:0]   o_max_usec
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMP,
        S_ABS,
        S_DIV1,
        S_MEAN,
        S_RMAG,
        S_MUL,
        S_SUM,
        S_DEC,
        S_DIV2,
        S_SQRT,
        S_DONE
    } t_state;

    t_state                 r_state;

    // Running statistics.
    logic [COUNT_BITS-1:0]  r_count;
    logic [MEAN_BITS-1:0]   r_mean;
    logic [SUM_BITS-1:0]    r_sds;
    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_max;

    // Per-sample working registers.
    logic [MEAN_BITS-1:0]   r_xq;
    logic                   r_neg;
    logic [MEAN_BITS-1:0]   r_dmag;
    logic [ALU_BITS-1:0]    r_q;
    logic [COUNT_BITS-1:0]  r_rem;
    logic [COUNT_BITS-1:0]  r_div;
    logic [PROD_BITS-1:0]   r_prod;
    logic [ALU_BITS-1:0]    r_root;
    logic [STD_BITS-1:0]    r_std;
    logic [ITER_BITS-1:0]   r_iter;

    // Output register.
    logic                   r_out_valid;
    logic [COUNT_BITS-1:0]  r_out_count;
    logic [MEAN_BITS-1:0]   r_out_mean;
    logic [STD_BITS-1:0]    r_out_std;
    logic [SAMPLE_BITS-1:0] r_out_min;
    logic [SAMPLE_BITS-1:0] r_out_max;

    // Shared adder connections.
    t_alu_op                w_op;
    logic [ALU_BITS-1:0]    w_a;
    logic [ALU_BITS-1:0]    w_b;
    logic [ALU_BITS-1:0]    w_res;
    logic                   w_carry;

    logic                   w_accept;
    logic [US_BITS-1:0]     w_x;
    logic [SAMPLE_BITS-1:0] w_packed;
    logic [COUNT_BITS:0]    w_shifted;
    logic [ALU_BITS-1:0]    w_bit;
    logic                   w_out_free;

    lrs_alu u_alu (
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_res   (w_res),
        .o_carry (w_carry)
    );

    // Sample conversion to whole microseconds and packed compare form.
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_x        = US_BITS'(i_sample_sec) * USEC_PER_SEC + US_BITS'(i_sample_usec);
    assign w_packed   = {i_sample_sec, i_sample_usec};
    assign w_shifted  = {r_rem, r_q[ALU_BITS-1]};
    assign w_bit      = ALU_BITS'(1) << {r_iter[ITER_BITS-2:0], 1'b0};
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Operand selection for the shared adder in each sequencer step.
    always_comb begin
        w_op = ALU_ADD;
        w_a  = '0;
        w_b  = '0;
        unique case (r_state)
            S_CMP: begin
                w_op = ALU_SUB;
                w_a  = ALU_BITS'(r_xq);
                w_b  = ALU_BITS'(r_mean);
            end
            S_ABS: begin
                w_op = ALU_SUB;
                w_a  = r_neg ? ALU_BITS'(r_mean) : ALU_BITS'(r_xq);
                w_b  = r_neg ? ALU_BITS'(r_xq) : ALU_BITS'(r_mean);
            end
            S_DIV1, S_DIV2: begin
                w_op = ALU_SUB;
                w_a  = ALU_BITS'(w_shifted);
                w_b  = ALU_BITS'(r_div);
            end
            S_MEAN: begin
                w_op = r_neg ? ALU_SUB : ALU_ADD;
                w_a  = ALU_BITS'(r_mean);
                w_b  = ALU_BITS'(r_q[MEAN_BITS-1:0]);
            end
            S_RMAG: begin
                w_op = ALU_SUB;
                w_a  = ALU_BITS'(r_dmag);
                w_b  = ALU_BITS'(r_q[MEAN_BITS-1:0]);
            end
            S_MUL: begin
                w_op = ALU_ADD;
                w_a  = ALU_BITS'(r_prod[PROD_BITS-1:MEAN_BITS]);
                w_b  = r_prod[0] ? ALU_BITS'(r_dmag) : '0;
            end
            S_SUM: begin
                w_op = ALU_ADD;
                w_a  = r_sds;
                w_b  = r_prod[PROD_BITS-1:2*FRAC_BITS];
            end
            S_DEC: begin
                w_op = ALU_SUB;
                w_a  = ALU_BITS'(r_count);
                w_b  = ALU_BITS'(1);
            end
            S_SQRT: begin
                w_op = ALU_SUB;
                w_a  = r_q;
                w_b  = r_root | w_bit;
            end
            default: begin
                w_op = ALU_ADD;
                w_a  = '0;
                w_b  = '0;
            end
        endcase
    end

    // Sequencer, running state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mean      <= '0;
            r_sds       <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The receiver has taken the pending result.
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_xq <= MEAN_BITS'(w_x) << FRAC_BITS;
                        if (r_count != '1) begin
                            r_count <= r_count + COUNT_BITS'(1);
                        end
                        if (w_packed < r_min || r_min == '0) begin
                            r_min <= w_packed;
                        end
                        if (w_packed > r_max) begin
                            r_max <= w_packed;
                        end
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_neg   <= !w_carry;
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    // Load the deviation magnitude as the dividend of the mean step.
                    r_dmag  <= w_res[MEAN_BITS-1:0];
                    r_q     <= {w_res[MEAN_BITS-1:0], {(ALU_BITS-MEAN_BITS){1'b0}}};
                    r_rem   <= '0;
                    r_div   <= r_count;
                    r_iter  <= '0;
                    r_state <= S_DIV1;
                end
                S_DIV1, S_DIV2: begin
                    // One restoring divide step: quotient bits shift in at the bottom.
                    if (w_carry) begin
                        r_rem <= w_res[COUNT_BITS-1:0];
                    end else begin
                        r_rem <= w_shifted[COUNT_BITS-1:0];
                    end
                    r_q    <= {r_q[ALU_BITS-2:0], w_carry};
                    r_iter <= r_iter + ITER_BITS'(1);
                    if (r_state == S_DIV1 && r_iter == ITER_BITS'(DIV1_STEPS - 1)) begin
                        r_state <= S_MEAN;
                    end else if (r_state == S_DIV2 &&
                                 r_iter == ITER_BITS'(DIV2_STEPS - 1)) begin
                        r_root  <= '0;
                        r_iter  <= ITER_BITS'(SQRT_STEPS - 1);
                        r_state <= S_SQRT;
                    end
                end
                S_MEAN: begin
                    r_mean  <= w_res[MEAN_BITS-1:0];
                    r_state <= S_RMAG;
                end
                S_RMAG: begin
                    // The multiplier goes into the low half of the accumulator.
                    r_prod  <= {{MEAN_BITS{1'b0}}, w_res[MEAN_BITS-1:0]};
                    r_iter  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // One shift-add multiply step.
                    r_prod <= {w_res[MEAN_BITS:0], r_prod[MEAN_BITS-1:1]};
                    r_iter <= r_iter + ITER_BITS'(1);
                    if (r_iter == ITER_BITS'(MUL_STEPS - 1)) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    // Saturating accumulate of the product of the old and new deviations.
                    r_sds <= w_carry ? '1 : w_res;
                    if (r_count < COUNT_BITS'(2)) begin
                        r_std   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_div   <= w_res[COUNT_BITS-1:0];
                    r_q     <= r_sds;
                    r_rem   <= '0;
                    r_iter  <= '0;
                    r_state <= S_DIV2;
                end
                S_SQRT: begin
                    // One bit of the integer square root of the variance.
                    if (w_carry) begin
                        r_q    <= w_res;
                        r_root <= (r_root >> 1) | w_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_iter <= r_iter - ITER_BITS'(1);
                    if (r_iter == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload captured at handover; std also cleared in S_SUM below two samples.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM && r_count < COUNT_BITS'(2)) begin
            r_out_std <= '0;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_count <= r_count;
            r_out_mean  <= r_mean;
            r_out_std   <= (r_count < COUNT_BITS'(2)) ? r_std : r_root[STD_BITS-1:0];
            r_out_min   <= r_min;
            r_out_max   <= r_max;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_sample_count = r_out_count;
    assign o_mean_q16     = r_out_mean;
    assign o_std_dev_us   = r_out_std;
    assign o_min_sec      = r_out_min[SAMPLE_BITS-1:USEC_BITS];
    assign o_min_usec     = r_out_min[USEC_BITS-1:0];
    assign o_max_sec      = r_out_max[SAMPLE_BITS-1:USEC_BITS];
    assign o_max_usec     = r_out_max[USEC_BITS-1:0];

endmodule
